### sv/wso_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wheel speed and odometer package
// Shared widths, configuration record, sequencer states and the command and
// status records that join the controller to the datapath.
// ----------------------------------------------------------------------------
package wso_pkg;

  localparam int WINDOW_LEN    = 8;
  localparam int SAMPLE_BITS   = 12;
  localparam int IN_BITS       = 12;
  localparam int POS_BITS      = $clog2(WINDOW_LEN);
  // Width that holds a negated input count and the sample limits alike.
  localparam int VBITS         = ((IN_BITS > SAMPLE_BITS) ? IN_BITS : SAMPLE_BITS) + 1;
  localparam int SUM_BITS      = 16;
  localparam int TOTAL_BITS    = 32;
  localparam int GAIN_BITS     = 24;
  localparam int PER_BITS      = 10;
  localparam int PPC_BITS      = 16;
  localparam int CSCALE_BITS   = 10;
  localparam int SPEED_BITS    = 32;
  localparam int ACC_BITS      = 48;
  localparam int LO_BITS       = 24;
  localparam int LO_PROD_BITS  = LO_BITS + PPC_BITS;
  localparam int MA_BITS       = 33;
  localparam int MB_BITS       = 25;
  localparam int PROD_BITS     = MA_BITS + MB_BITS;
  localparam int CMQ_BITS      = PROD_BITS - 16;
  localparam int DQ_BITS       = 42;
  localparam int IN_DATA_BITS  = 2 * IN_BITS;
  localparam int OUT_DATA_BITS = 2 * SUM_BITS + 9 * SPEED_BITS;
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;

  typedef enum logic [2:0] {
    REG_RIGHT_INVERT,
    REG_LEFT_INVERT,
    REG_RIGHT_GAIN,
    REG_LEFT_GAIN,
    REG_TICK_PERIOD,
    REG_PULSES_PER_CM,
    REG_CM_SCALE
  } reg_idx_t;

  typedef struct packed {
    logic                   right_invert;
    logic                   left_invert;
    logic [GAIN_BITS-1:0]   right_speed_gain;
    logic [GAIN_BITS-1:0]   left_speed_gain;
    logic [PER_BITS-1:0]    tick_period_ms;
    logic [PPC_BITS-1:0]    pulses_per_cm;
    logic [CSCALE_BITS-1:0] centimetre_scale;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_R,
    ST_MUL_L,
    ST_SAT_L,
    ST_CAR,
    ST_CM,
    ST_ACC_L,
    ST_ACC_C,
    ST_RD_LO,
    ST_RD_HI,
    ST_LD_LO,
    ST_LD_HI,
    ST_CD_LO,
    ST_CD_HI,
    ST_CD_FIN,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    MA_RSUM,
    MA_LSUM,
    MA_RSP,
    MA_LSP,
    MA_CAR,
    MA_RACC_LO,
    MA_RACC_HI,
    MA_LACC_LO,
    MA_LACC_HI,
    MA_CACC_LO,
    MA_CACC_HI
  } mul_a_sel_t;

  typedef enum logic [2:0] {
    MB_RGAIN,
    MB_LGAIN,
    MB_PERIOD,
    MB_CSCALE,
    MB_PPC
  } mul_b_sel_t;

  typedef struct packed {
    mul_a_sel_t mul_a;
    mul_b_sel_t mul_b;
    logic       ld_item;
    logic       wr_rsp;
    logic       wr_lsp;
    logic       wr_car;
    logic       wr_racc;
    logic       wr_cm;
    logic       wr_lacc;
    logic       wr_cacc;
    logic       wr_lo;
    logic       wr_rdist;
    logic       wr_ldist;
    logic       wr_cdist;
    logic       ld_out;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

### sv/wso_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wheel speed and odometer controller
// Steps one request through the shared multiplier schedule and hands the
// finished result to the output register.
// ----------------------------------------------------------------------------
module wso_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire wso_pkg::sts_t sts,
  output wso_pkg::cmd_t      cmd
);

  wso_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wso_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wso_pkg::ST_IDLE:   if (in_tvalid) state_nxt = wso_pkg::ST_MUL_R;
      wso_pkg::ST_MUL_R:  state_nxt = wso_pkg::ST_MUL_L;
      wso_pkg::ST_MUL_L:  state_nxt = wso_pkg::ST_SAT_L;
      wso_pkg::ST_SAT_L:  state_nxt = wso_pkg::ST_CAR;
      wso_pkg::ST_CAR:    state_nxt = wso_pkg::ST_CM;
      wso_pkg::ST_CM:     state_nxt = wso_pkg::ST_ACC_L;
      wso_pkg::ST_ACC_L:  state_nxt = wso_pkg::ST_ACC_C;
      wso_pkg::ST_ACC_C:  state_nxt = wso_pkg::ST_RD_LO;
      wso_pkg::ST_RD_LO:  state_nxt = wso_pkg::ST_RD_HI;
      wso_pkg::ST_RD_HI:  state_nxt = wso_pkg::ST_LD_LO;
      wso_pkg::ST_LD_LO:  state_nxt = wso_pkg::ST_LD_HI;
      wso_pkg::ST_LD_HI:  state_nxt = wso_pkg::ST_CD_LO;
      wso_pkg::ST_CD_LO:  state_nxt = wso_pkg::ST_CD_HI;
      wso_pkg::ST_CD_HI:  state_nxt = wso_pkg::ST_CD_FIN;
      wso_pkg::ST_CD_FIN: state_nxt = wso_pkg::ST_DONE;
      wso_pkg::ST_DONE:   if (!sts.out_busy) state_nxt = wso_pkg::ST_IDLE;
      default:            state_nxt = wso_pkg::ST_IDLE;
    endcase
  end

  // Each step names the multiplier operands for this cycle and the register
  // that takes the product registered in the cycle before.
  always_comb begin
    cmd       = '0;
    cmd.mul_a = wso_pkg::MA_RSUM;
    cmd.mul_b = wso_pkg::MB_RGAIN;
    in_tready = 1'b0;
    unique case (state_r)
      wso_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.ld_item = in_tvalid;
      end
      wso_pkg::ST_MUL_R: begin
        cmd.mul_a = wso_pkg::MA_RSUM;
        cmd.mul_b = wso_pkg::MB_RGAIN;
      end
      wso_pkg::ST_MUL_L: begin
        cmd.mul_a  = wso_pkg::MA_LSUM;
        cmd.mul_b  = wso_pkg::MB_LGAIN;
        cmd.wr_rsp = 1'b1;
      end
      wso_pkg::ST_SAT_L: cmd.wr_lsp = 1'b1;
      wso_pkg::ST_CAR: begin
        cmd.mul_a  = wso_pkg::MA_RSP;
        cmd.mul_b  = wso_pkg::MB_PERIOD;
        cmd.wr_car = 1'b1;
      end
      wso_pkg::ST_CM: begin
        cmd.mul_a   = wso_pkg::MA_CAR;
        cmd.mul_b   = wso_pkg::MB_CSCALE;
        cmd.wr_racc = 1'b1;
      end
      wso_pkg::ST_ACC_L: begin
        cmd.mul_a = wso_pkg::MA_LSP;
        cmd.mul_b = wso_pkg::MB_PERIOD;
        cmd.wr_cm = 1'b1;
      end
      wso_pkg::ST_ACC_C: begin
        cmd.mul_a   = wso_pkg::MA_CAR;
        cmd.mul_b   = wso_pkg::MB_PERIOD;
        cmd.wr_lacc = 1'b1;
      end
      wso_pkg::ST_RD_LO: begin
        cmd.mul_a   = wso_pkg::MA_RACC_LO;
        cmd.mul_b   = wso_pkg::MB_PPC;
        cmd.wr_cacc = 1'b1;
      end
      wso_pkg::ST_RD_HI: begin
        cmd.mul_a = wso_pkg::MA_RACC_HI;
        cmd.mul_b = wso_pkg::MB_PPC;
        cmd.wr_lo = 1'b1;
      end
      wso_pkg::ST_LD_LO: begin
        cmd.mul_a    = wso_pkg::MA_LACC_LO;
        cmd.mul_b    = wso_pkg::MB_PPC;
        cmd.wr_rdist = 1'b1;
      end
      wso_pkg::ST_LD_HI: begin
        cmd.mul_a = wso_pkg::MA_LACC_HI;
        cmd.mul_b = wso_pkg::MB_PPC;
        cmd.wr_lo = 1'b1;
      end
      wso_pkg::ST_CD_LO: begin
        cmd.mul_a    = wso_pkg::MA_CACC_LO;
        cmd.mul_b    = wso_pkg::MB_PPC;
        cmd.wr_ldist = 1'b1;
      end
      wso_pkg::ST_CD_HI: begin
        cmd.mul_a = wso_pkg::MA_CACC_HI;
        cmd.mul_b = wso_pkg::MB_PPC;
        cmd.wr_lo = 1'b1;
      end
      wso_pkg::ST_CD_FIN: cmd.wr_cdist = 1'b1;
      wso_pkg::ST_DONE:   cmd.ld_out   = !sts.out_busy;
      default: begin
        cmd.mul_a = wso_pkg::MA_RSUM;
        cmd.mul_b = wso_pkg::MB_RGAIN;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_item_starts_schedule: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_item |=> state_r == wso_pkg::ST_MUL_R && !in_tready)
    else $error("accepted request did not start the multiplier schedule");

  a_no_overwrite_of_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> !sts.out_busy)
    else $error("output register loaded while still holding a result");

  a_one_write_per_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_rsp, cmd.wr_lsp, cmd.wr_car, cmd.wr_racc, cmd.wr_cm, cmd.wr_lacc,
              cmd.wr_cacc, cmd.wr_lo, cmd.wr_rdist, cmd.wr_ldist, cmd.wr_cdist}))
    else $error("more than one product consumer in one step");

  a_item_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_item |-> ##15 state_r == wso_pkg::ST_DONE)
    else $error("schedule length differs from fifteen steps");
`endif

endmodule
`default_nettype wire

### sv/wso_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wheel speed and odometer datapath
// Sample rings with running sums, count totals, one shared multiplier, the
// distance accumulators and the output register.
// ----------------------------------------------------------------------------
module wso_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire wso_pkg::cfg_t                      cfg,
  input  wire logic [wso_pkg::IN_DATA_BITS-1:0]   in_data,
  input  wire wso_pkg::cmd_t                      cmd,
  output wso_pkg::sts_t                           sts,
  input  wire logic                               out_tready,
  output logic                                    out_tvalid,
  output logic [wso_pkg::OUT_DATA_BITS-1:0]       out_tdata
);

  localparam logic signed [wso_pkg::VBITS-1:0] SMAX =
    wso_pkg::VBITS'((2 ** (wso_pkg::SAMPLE_BITS - 1)) - 1);
  localparam logic signed [wso_pkg::VBITS-1:0] SMIN = -SMAX - 1;
  localparam logic signed [wso_pkg::PROD_BITS-1:0] P32_MAX =
    $signed({{(wso_pkg::PROD_BITS - 31){1'b0}}, {31{1'b1}}});
  localparam logic signed [wso_pkg::PROD_BITS-1:0] P32_MIN =
    $signed({{(wso_pkg::PROD_BITS - 31){1'b1}}, {31{1'b0}}});
  localparam logic signed [wso_pkg::ACC_BITS:0] ACC_MAX =
    $signed({2'b00, {(wso_pkg::ACC_BITS - 1){1'b1}}});
  localparam logic signed [wso_pkg::ACC_BITS:0] ACC_MIN =
    $signed({2'b11, {(wso_pkg::ACC_BITS - 1){1'b0}}});

  function automatic wso_pkg::sample_t sample_of(input logic [wso_pkg::IN_BITS-1:0] raw,
                                                 input logic inv);
    logic signed [wso_pkg::VBITS-1:0] v;
    v = wso_pkg::VBITS'($signed(raw));
    if (inv) v = -v;
    if (v > SMAX) v = SMAX;
    else if (v < SMIN) v = SMIN;
    return wso_pkg::sample_t'(v[wso_pkg::SAMPLE_BITS-1:0]);
  endfunction

  function automatic logic [wso_pkg::SPEED_BITS-1:0] sat32(
      input logic signed [wso_pkg::PROD_BITS-1:0] v);
    logic signed [wso_pkg::PROD_BITS-1:0] s;
    s = v;
    if (v > P32_MAX) s = P32_MAX;
    else if (v < P32_MIN) s = P32_MIN;
    return s[wso_pkg::SPEED_BITS-1:0];
  endfunction

  function automatic logic [wso_pkg::ACC_BITS-1:0] acc_add(
      input logic [wso_pkg::ACC_BITS-1:0]         acc,
      input logic signed [wso_pkg::PROD_BITS-1:0] p);
    logic signed [wso_pkg::ACC_BITS:0] s;
    s = (wso_pkg::ACC_BITS + 1)'($signed(acc)) + $signed(p[wso_pkg::ACC_BITS:0]);
    if (s > ACC_MAX) s = ACC_MAX;
    else if (s < ACC_MIN) s = ACC_MIN;
    return s[wso_pkg::ACC_BITS-1:0];
  endfunction

  // Sample rings and running window sums.
  wso_pkg::sample_t            right_ring_r [wso_pkg::WINDOW_LEN];
  wso_pkg::sample_t            left_ring_r  [wso_pkg::WINDOW_LEN];
  logic [wso_pkg::POS_BITS-1:0] pos_r, pos_nxt;
  logic                         primed_r;
  wso_pkg::sum_t                rsum_r, rsum_nxt, lsum_r, lsum_nxt;
  logic [wso_pkg::TOTAL_BITS-1:0] rtot_r, ltot_r;

  wso_pkg::sample_t rs, ls;
  wso_pkg::sum_t    rs_w, ls_w;

  assign rs   = sample_of(in_data[wso_pkg::IN_BITS-1:0], cfg.right_invert);
  assign ls   = sample_of(in_data[2*wso_pkg::IN_BITS-1:wso_pkg::IN_BITS], cfg.left_invert);
  assign rs_w = wso_pkg::sum_t'(rs);
  assign ls_w = wso_pkg::sum_t'(ls);

  assign pos_nxt = (pos_r == wso_pkg::POS_BITS'(wso_pkg::WINDOW_LEN - 1)) ?
                   '0 : pos_r + 1'b1;

  // The priming request fills the whole ring, so its sum is the sample times
  // the window length, wrapped like every other sum.
  always_comb begin
    if (primed_r) begin
      rsum_nxt = rsum_r - wso_pkg::sum_t'(right_ring_r[pos_r]) + rs_w;
      lsum_nxt = lsum_r - wso_pkg::sum_t'(left_ring_r[pos_r]) + ls_w;
    end else begin
      rsum_nxt = wso_pkg::sum_t'(rs_w * $signed(wso_pkg::SUM_BITS'(wso_pkg::WINDOW_LEN)));
      lsum_nxt = wso_pkg::sum_t'(ls_w * $signed(wso_pkg::SUM_BITS'(wso_pkg::WINDOW_LEN)));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      rsum_r <= rsum_nxt;
      lsum_r <= lsum_nxt;
      if (primed_r) begin
        right_ring_r[pos_r] <= rs;
        left_ring_r[pos_r]  <= ls;
      end else begin
        for (int i = 0; i < wso_pkg::WINDOW_LEN; i++) begin
          right_ring_r[i] <= rs;
          left_ring_r[i]  <= ls;
        end
      end
    end
  end

  // Shared multiplier.
  logic signed [wso_pkg::MA_BITS-1:0]   ma;
  logic signed [wso_pkg::MB_BITS-1:0]   mb;
  logic signed [wso_pkg::PROD_BITS-1:0] prod_r;

  logic [wso_pkg::SPEED_BITS-1:0] rsp_r, lsp_r, car_r, cm_r;
  logic [wso_pkg::SPEED_BITS-1:0] rdist_r, ldist_r, cdist_r;
  logic [wso_pkg::ACC_BITS-1:0]   racc_r, lacc_r, cacc_r;
  logic [wso_pkg::LO_PROD_BITS-1:0] lo_r;

  always_comb begin
    unique case (cmd.mul_a)
      wso_pkg::MA_RSUM:    ma = wso_pkg::MA_BITS'(rsum_r);
      wso_pkg::MA_LSUM:    ma = wso_pkg::MA_BITS'(lsum_r);
      wso_pkg::MA_RSP:     ma = wso_pkg::MA_BITS'($signed(rsp_r));
      wso_pkg::MA_LSP:     ma = wso_pkg::MA_BITS'($signed(lsp_r));
      wso_pkg::MA_CAR:     ma = wso_pkg::MA_BITS'($signed(car_r));
      wso_pkg::MA_RACC_LO: ma = wso_pkg::MA_BITS'(racc_r[wso_pkg::LO_BITS-1:0]);
      wso_pkg::MA_RACC_HI:
        ma = wso_pkg::MA_BITS'($signed(racc_r[wso_pkg::ACC_BITS-1:wso_pkg::LO_BITS]));
      wso_pkg::MA_LACC_LO: ma = wso_pkg::MA_BITS'(lacc_r[wso_pkg::LO_BITS-1:0]);
      wso_pkg::MA_LACC_HI:
        ma = wso_pkg::MA_BITS'($signed(lacc_r[wso_pkg::ACC_BITS-1:wso_pkg::LO_BITS]));
      wso_pkg::MA_CACC_LO: ma = wso_pkg::MA_BITS'(cacc_r[wso_pkg::LO_BITS-1:0]);
      wso_pkg::MA_CACC_HI:
        ma = wso_pkg::MA_BITS'($signed(cacc_r[wso_pkg::ACC_BITS-1:wso_pkg::LO_BITS]));
      default:             ma = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.mul_b)
      wso_pkg::MB_RGAIN:  mb = wso_pkg::MB_BITS'(cfg.right_speed_gain);
      wso_pkg::MB_LGAIN:  mb = wso_pkg::MB_BITS'(cfg.left_speed_gain);
      wso_pkg::MB_PERIOD: mb = wso_pkg::MB_BITS'(cfg.tick_period_ms);
      wso_pkg::MB_CSCALE: mb = wso_pkg::MB_BITS'(cfg.centimetre_scale);
      wso_pkg::MB_PPC:    mb = wso_pkg::MB_BITS'(cfg.pulses_per_cm);
      default:            mb = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
  end

  // Floor mean of the wheel speeds.
  logic [wso_pkg::SPEED_BITS:0] car_sum;
  assign car_sum = {rsp_r[wso_pkg::SPEED_BITS-1], rsp_r} +
                   {lsp_r[wso_pkg::SPEED_BITS-1], lsp_r};

  // Centimetre speed: divide by 2^16 rounding toward zero.
  logic                          cm_rnd;
  logic [wso_pkg::CMQ_BITS-1:0]  cm_q;
  assign cm_rnd = prod_r[wso_pkg::PROD_BITS-1] && (|prod_r[15:0]);
  assign cm_q   = prod_r[wso_pkg::PROD_BITS-1:16] + wso_pkg::CMQ_BITS'(cm_rnd);

  // Distance: the upper partial product sits 24 bits up, so only the upper
  // bits of the lower partial product join the add, and the quotient by 2^24
  // rounds toward zero when any of the dropped bits is set.
  logic [wso_pkg::DQ_BITS-1:0] d_hi, d_q;
  logic                        d_rnd;
  assign d_hi  = prod_r[wso_pkg::DQ_BITS-1:0] +
                 wso_pkg::DQ_BITS'(lo_r[wso_pkg::LO_PROD_BITS-1:wso_pkg::LO_BITS]);
  assign d_rnd = d_hi[wso_pkg::DQ_BITS-1] && (|lo_r[wso_pkg::LO_BITS-1:0]);
  assign d_q   = d_hi + wso_pkg::DQ_BITS'(d_rnd);

  logic [wso_pkg::SPEED_BITS-1:0] d_sat;
  assign d_sat = sat32(wso_pkg::PROD_BITS'($signed(d_q)));

  always_ff @(posedge clk) begin
    if (cmd.wr_rsp)   rsp_r   <= sat32(prod_r);
    if (cmd.wr_lsp)   lsp_r   <= sat32(prod_r);
    if (cmd.wr_car)   car_r   <= car_sum[wso_pkg::SPEED_BITS:1];
    if (cmd.wr_cm)    cm_r    <= cm_q[wso_pkg::SPEED_BITS-1:0];
    if (cmd.wr_lo)    lo_r    <= prod_r[wso_pkg::LO_PROD_BITS-1:0];
    if (cmd.wr_rdist) rdist_r <= d_sat;
    if (cmd.wr_ldist) ldist_r <= d_sat;
    if (cmd.wr_cdist) cdist_r <= d_sat;
  end

  logic [wso_pkg::OUT_DATA_BITS-1:0] out_data_r;
  logic                              out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      primed_r    <= 1'b0;
      rtot_r      <= '0;
      ltot_r      <= '0;
      racc_r      <= '0;
      lacc_r      <= '0;
      cacc_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ld_item) begin
        primed_r <= 1'b1;
        if (primed_r) pos_r <= pos_nxt;
        rtot_r <= rtot_r + wso_pkg::TOTAL_BITS'(rsum_nxt);
        ltot_r <= ltot_r + wso_pkg::TOTAL_BITS'(lsum_nxt);
      end
      if (cmd.wr_racc) racc_r <= acc_add(racc_r, prod_r);
      if (cmd.wr_lacc) lacc_r <= acc_add(lacc_r, prod_r);
      if (cmd.wr_cacc) cacc_r <= acc_add(cacc_r, prod_r);
      if (cmd.ld_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_data_r <= {rdist_r, ldist_r, cdist_r, ltot_r, rtot_r, cm_r, car_r,
                     lsp_r, rsp_r, lsum_r, rsum_r};
    end
  end

  assign sts.out_busy = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

endmodule
`default_nettype wire

### sv/wheel_encoder_speed_odometer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wheel encoder speed and odometer core
// Moving-average wheel speed, car speed and integrated distance from
// per-tick encoder pulse counts, with an APB-style register port.
// ----------------------------------------------------------------------------
// A result is offered on out_tvalid when the schedule for its request ends,
// and stays until the sink takes it.
// Requests are taken one at a time; the schedule is paced by the one
// shared 33 x 25 bit multiplier, which does twelve scalings per request.
// A waiting result does not hold the next request back until its own result
// is ready to enter the output register.
// Reset (rst_n, synchronous): rings unprimed, totals and accumulators zero,
// registers at their documented defaults. There is no clearing pass.
module wheel_encoder_speed_odometer_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input requests.
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [11:0] right_pulses, [23:12] left_pulses
  input  wire logic [wso_pkg::IN_DATA_BITS-1:0]    in_tdata,
  // Results.
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [15:0] right_window_sum, [31:16] left_window_sum, [63:32] right_speed,
  // [95:64] left_speed, [127:96] car_speed, [159:128] car_speed_cm,
  // [191:160] right_count_total, [223:192] left_count_total,
  // [255:224] car_distance, [287:256] left_distance, [319:288] right_distance
  output logic [wso_pkg::OUT_DATA_BITS-1:0]        out_tdata,
  // Register port.
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [wso_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  wire logic [wso_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [wso_pkg::CFG_DATA_BITS-1:0]        prdata,
  output logic                                     pready
);

  // --------------------------------------------------------------------------
  // Configuration registers. Registers lie on word addresses; the register
  // index is the word offset, and offsets past the last register are ignored.
  // Only the low bits of each register are kept.
  // --------------------------------------------------------------------------
  wso_pkg::cfg_t     cfg_r;
  wso_pkg::reg_idx_t reg_idx;
  logic              reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = wso_pkg::reg_idx_t'(paddr[wso_pkg::CFG_ADDR_BITS-1:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.right_invert     <= 1'b1;
      cfg_r.left_invert      <= 1'b0;
      cfg_r.right_speed_gain <= '0;
      cfg_r.left_speed_gain  <= '0;
      cfg_r.tick_period_ms   <= wso_pkg::PER_BITS'(5);
      cfg_r.pulses_per_cm    <= '0;
      cfg_r.centimetre_scale <= wso_pkg::CSCALE_BITS'(100);
    end else if (reg_wr) begin
      unique case (reg_idx)
        wso_pkg::REG_RIGHT_INVERT:  cfg_r.right_invert     <= pwdata[0];
        wso_pkg::REG_LEFT_INVERT:   cfg_r.left_invert      <= pwdata[0];
        wso_pkg::REG_RIGHT_GAIN:
          cfg_r.right_speed_gain <= pwdata[wso_pkg::GAIN_BITS-1:0];
        wso_pkg::REG_LEFT_GAIN:
          cfg_r.left_speed_gain  <= pwdata[wso_pkg::GAIN_BITS-1:0];
        wso_pkg::REG_TICK_PERIOD:
          cfg_r.tick_period_ms   <= pwdata[wso_pkg::PER_BITS-1:0];
        wso_pkg::REG_PULSES_PER_CM:
          cfg_r.pulses_per_cm    <= pwdata[wso_pkg::PPC_BITS-1:0];
        wso_pkg::REG_CM_SCALE:
          cfg_r.centimetre_scale <= pwdata[wso_pkg::CSCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read-back returns the stored register value, zero above its width.
  always_comb begin
    unique case (reg_idx)
      wso_pkg::REG_RIGHT_INVERT:  prdata = wso_pkg::CFG_DATA_BITS'(cfg_r.right_invert);
      wso_pkg::REG_LEFT_INVERT:   prdata = wso_pkg::CFG_DATA_BITS'(cfg_r.left_invert);
      wso_pkg::REG_RIGHT_GAIN:    prdata = wso_pkg::CFG_DATA_BITS'(cfg_r.right_speed_gain);
      wso_pkg::REG_LEFT_GAIN:     prdata = wso_pkg::CFG_DATA_BITS'(cfg_r.left_speed_gain);
      wso_pkg::REG_TICK_PERIOD:   prdata = wso_pkg::CFG_DATA_BITS'(cfg_r.tick_period_ms);
      wso_pkg::REG_PULSES_PER_CM: prdata = wso_pkg::CFG_DATA_BITS'(cfg_r.pulses_per_cm);
      wso_pkg::REG_CM_SCALE:      prdata = wso_pkg::CFG_DATA_BITS'(cfg_r.centimetre_scale);
      default:                    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // The controller owns the schedule; the datapath holds every value and the
  // output register. They talk only through the command and status records.
  // --------------------------------------------------------------------------
  wso_pkg::cmd_t cmd;
  wso_pkg::sts_t sts;

  wso_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wso_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_data    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

### tb/wheel_encoder_speed_odometer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel encoder speed and odometer core testbench
// Sends encoder pulse-count requests through the streaming input and keeps a
// bit-accurate local copy of the rings, totals and distance accumulators.
// Every returned record is compared field by field with the oldest predicted
// one. Register settings change between phases through the APB-style port,
// and the receiver stalls on its own pattern, once for a long stretch.
// ----------------------------------------------------------------------------
module wheel_encoder_speed_odometer_core_tb;
  import wso_pkg::*;

  localparam int HALF_PERIOD      = 10;
  localparam int RESET_CYCLES     = 12;
  localparam int MAX_REPORTS      = 10;
  localparam int DRAIN_LIMIT      = 20000;
  localparam int TAIL_CYCLES      = 40;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES    = 12;
  localparam int TICKS_PER_PHASE  = 145;
  localparam int PRESSURE_TICKS   = 24;
  localparam int GAIN_MAX         = 2**GAIN_BITS - 1;
  localparam int PPC_MAX          = 2**PPC_BITS - 1;
  localparam int PERIOD_MAX       = 1000;
  localparam int CSCALE_MAX       = 1000;

  // Byte address beyond the last register; writes there must change nothing.
  localparam logic [CFG_ADDR_BITS-1:0] UNUSED_REG_ADDR = 5'd28;

  localparam longint SAMPLE_MAX = 2**(SAMPLE_BITS-1) - 1;
  localparam longint SPEED_MAX  = 64'sd2147483647;
  localparam longint SPEED_MIN  = -SPEED_MAX - 1;
  localparam longint ACC_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_MIN    = -ACC_MAX - 1;

  // How the result side paces out_tready when no long hold is running.
  typedef enum int {
    SINK_ALWAYS,
    SINK_COIN,
    SINK_MOSTLY,
    SINK_PERIODIC
  } sink_mode_t;

  // One result record, laid out exactly as out_tdata (first field highest).
  typedef struct packed {
    logic [SPEED_BITS-1:0] right_distance;
    logic [SPEED_BITS-1:0] left_distance;
    logic [SPEED_BITS-1:0] car_distance;
    logic [TOTAL_BITS-1:0] left_count_total;
    logic [TOTAL_BITS-1:0] right_count_total;
    logic [SPEED_BITS-1:0] car_speed_cm;
    logic [SPEED_BITS-1:0] car_speed;
    logic [SPEED_BITS-1:0] left_speed;
    logic [SPEED_BITS-1:0] right_speed;
    logic [SUM_BITS-1:0]   left_window_sum;
    logic [SUM_BITS-1:0]   right_window_sum;
  } odometry_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  // Local copy of the block's registers and state.
  cfg_t                  shadow_cfg;
  int                    right_ring_copy [WINDOW_LEN];
  int                    left_ring_copy  [WINDOW_LEN];
  int                    ring_slot;
  bit                    rings_primed;
  logic [TOTAL_BITS-1:0] right_total_copy;
  logic [TOTAL_BITS-1:0] left_total_copy;
  longint                car_travel;
  longint                left_travel;
  longint                right_travel;

  // Records predicted for accepted requests, oldest first.
  odometry_t pending_odometry [$];

  int error_count    = 0;
  int result_count   = 0;
  int stall_requests = 0;
  int burst_left     = 0;

  wheel_encoder_speed_odometer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Optional negation, then saturation to the sample width, so that negating
  // the most negative count yields the largest positive sample.
  function automatic int condition_sample(logic [IN_BITS-1:0] raw, logic negate);
    longint v;
    v = longint'($signed(raw));
    if (negate) v = -v;
    return int'(clamp(v, -SAMPLE_MAX - 1, SAMPLE_MAX));
  endfunction

  // Accumulator times pulses per cm in Q8.8 over 2^24, truncated toward zero.
  function automatic logic [SPEED_BITS-1:0] scaled_distance(longint acc, longint ppc);
    longint d;
    d = clamp((acc * ppc) / 64'sd16777216, SPEED_MIN, SPEED_MAX);
    return d[SPEED_BITS-1:0];
  endfunction

  function automatic void reset_odometry();
    shadow_cfg = '{right_invert: 1'b1, left_invert: 1'b0, right_speed_gain: '0,
                   left_speed_gain: '0, tick_period_ms: 10'd5, pulses_per_cm: '0,
                   centimetre_scale: 10'd100};
    foreach (right_ring_copy[i]) begin
      right_ring_copy[i] = 0;
      left_ring_copy[i]  = 0;
    end
    ring_slot        = 0;
    rings_primed     = 1'b0;
    right_total_copy = '0;
    left_total_copy  = '0;
    car_travel       = 0;
    left_travel      = 0;
    right_travel     = 0;
  endfunction

  function automatic odometry_t predict_odometry(logic [IN_BITS-1:0] right_raw,
                                                 logic [IN_BITS-1:0] left_raw);
    odometry_t           r;
    int                  rs, ls, rsum_raw, lsum_raw;
    logic [SUM_BITS-1:0] rwrap, lwrap;
    longint              rsum, lsum, rsp, lsp, car, cm;
    longint              rgain, lgain, per, ppc, cscale;
    rs = condition_sample(right_raw, shadow_cfg.right_invert);
    ls = condition_sample(left_raw, shadow_cfg.left_invert);
    // The priming tick floods both rings and leaves the write slot alone.
    if (!rings_primed) begin
      foreach (right_ring_copy[i]) begin
        right_ring_copy[i] = rs;
        left_ring_copy[i]  = ls;
      end
      rings_primed = 1'b1;
    end else begin
      right_ring_copy[ring_slot] = rs;
      left_ring_copy[ring_slot]  = ls;
      ring_slot = (ring_slot + 1 >= WINDOW_LEN) ? 0 : ring_slot + 1;
    end
    rsum_raw = 0;
    lsum_raw = 0;
    foreach (right_ring_copy[i]) begin
      rsum_raw += right_ring_copy[i];
      lsum_raw += left_ring_copy[i];
    end
    // Sums wrap to 16 bits, and the wrapped value feeds everything after.
    rwrap = rsum_raw[SUM_BITS-1:0];
    lwrap = lsum_raw[SUM_BITS-1:0];
    rsum  = longint'($signed(rwrap));
    lsum  = longint'($signed(lwrap));
    right_total_copy = right_total_copy + rsum[TOTAL_BITS-1:0];
    left_total_copy  = left_total_copy + lsum[TOTAL_BITS-1:0];

    rgain  = shadow_cfg.right_speed_gain;
    lgain  = shadow_cfg.left_speed_gain;
    per    = shadow_cfg.tick_period_ms;
    ppc    = shadow_cfg.pulses_per_cm;
    cscale = shadow_cfg.centimetre_scale;
    rsp = clamp(rsum * rgain, SPEED_MIN, SPEED_MAX);
    lsp = clamp(lsum * lgain, SPEED_MIN, SPEED_MAX);
    car = (rsp + lsp) >>> 1;
    cm  = (car * cscale) / 64'sd65536;

    car_travel   = clamp(car_travel + car * per, ACC_MIN, ACC_MAX);
    left_travel  = clamp(left_travel + lsp * per, ACC_MIN, ACC_MAX);
    right_travel = clamp(right_travel + rsp * per, ACC_MIN, ACC_MAX);

    r.right_window_sum  = rwrap;
    r.left_window_sum   = lwrap;
    r.right_speed       = rsp[SPEED_BITS-1:0];
    r.left_speed        = lsp[SPEED_BITS-1:0];
    r.car_speed         = car[SPEED_BITS-1:0];
    r.car_speed_cm      = cm[SPEED_BITS-1:0];
    r.right_count_total = right_total_copy;
    r.left_count_total  = left_total_copy;
    r.car_distance      = scaled_distance(car_travel, ppc);
    r.left_distance     = scaled_distance(left_travel, ppc);
    r.right_distance    = scaled_distance(right_travel, ppc);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------

  function automatic logic [CFG_ADDR_BITS-1:0] reg_addr(reg_idx_t idx);
    return {idx, 2'b00};
  endfunction

  // Register contents as a read should return them, high bits zero.
  function automatic logic [CFG_DATA_BITS-1:0] register_image(reg_idx_t idx);
    logic [CFG_DATA_BITS-1:0] v;
    v = '0;
    case (idx)
      REG_RIGHT_INVERT:  v[0] = shadow_cfg.right_invert;
      REG_LEFT_INVERT:   v[0] = shadow_cfg.left_invert;
      REG_RIGHT_GAIN:    v[GAIN_BITS-1:0] = shadow_cfg.right_speed_gain;
      REG_LEFT_GAIN:     v[GAIN_BITS-1:0] = shadow_cfg.left_speed_gain;
      REG_TICK_PERIOD:   v[PER_BITS-1:0] = shadow_cfg.tick_period_ms;
      REG_PULSES_PER_CM: v[PPC_BITS-1:0] = shadow_cfg.pulses_per_cm;
      REG_CM_SCALE:      v[CSCALE_BITS-1:0] = shadow_cfg.centimetre_scale;
      default:           v = '0;
    endcase
    return v;
  endfunction

  // Writes mask off the bits above each register's width; unknown addresses
  // are ignored.
  function automatic void note_register_write(logic [CFG_ADDR_BITS-1:0] addr,
                                              logic [CFG_DATA_BITS-1:0] value);
    case (addr[CFG_ADDR_BITS-1:2])
      REG_RIGHT_INVERT:  shadow_cfg.right_invert     = value[0];
      REG_LEFT_INVERT:   shadow_cfg.left_invert      = value[0];
      REG_RIGHT_GAIN:    shadow_cfg.right_speed_gain = value[GAIN_BITS-1:0];
      REG_LEFT_GAIN:     shadow_cfg.left_speed_gain  = value[GAIN_BITS-1:0];
      REG_TICK_PERIOD:   shadow_cfg.tick_period_ms   = value[PER_BITS-1:0];
      REG_PULSES_PER_CM: shadow_cfg.pulses_per_cm    = value[PPC_BITS-1:0];
      REG_CM_SCALE:      shadow_cfg.centimetre_scale = value[CSCALE_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Setup cycle, then access cycle; the write lands at the access edge.
  task automatic apb_write(input logic [CFG_ADDR_BITS-1:0] addr,
                           input logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    note_register_write(addr, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_register(input reg_idx_t idx);
    logic [CFG_DATA_BITS-1:0] seen;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_addr(idx);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    seen = prdata;
    if (seen !== register_image(idx))
      report_error($sformatf("register %s read 0x%08h, expected 0x%08h",
                             idx.name(), seen, register_image(idx)));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_settings(input bit r_inv, input bit l_inv, input int r_gain,
                                input int l_gain, input int period, input int ppc,
                                input int cscale);
    apb_write(reg_addr(REG_RIGHT_INVERT), r_inv);
    apb_write(reg_addr(REG_LEFT_INVERT), l_inv);
    apb_write(reg_addr(REG_RIGHT_GAIN), r_gain);
    apb_write(reg_addr(REG_LEFT_GAIN), l_gain);
    apb_write(reg_addr(REG_TICK_PERIOD), period);
    apb_write(reg_addr(REG_PULSES_PER_CM), ppc);
    apb_write(reg_addr(REG_CM_SCALE), cscale);
  endtask

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one tick and hold it until the block takes it. The expected record
  // is computed at the accepting edge with the settings in force then.
  task automatic offer_tick(input logic [IN_BITS-1:0] right_raw,
                            input logic [IN_BITS-1:0] left_raw);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {left_raw, right_raw};
    do @(posedge clk); while (!in_tready);
    pending_odometry.push_back(predict_odometry(right_raw, left_raw));
  endtask

  // Bursts of random length, some long enough to keep the input saturated,
  // separated by gaps of random length so that requests land on every step
  // of the block's schedule.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    gap = $urandom_range(1, 20);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (gap - 1) @(negedge clk);
  endtask

  // Drop the request line and let every outstanding record come back, so
  // that the registers can be rewritten with the block idle.
  task automatic wait_idle();
    int waited;
    waited = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_odometry.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Corner counts about a third of the time, otherwise counts leaning toward
  // one direction when the phase asks for it.
  function automatic logic [IN_BITS-1:0] pick_pulses(int bias);
    int v;
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 5))
        0:       v = -2048;
        1:       v = 2047;
        2:       v = 0;
        3:       v = -1;
        4:       v = 1;
        default: v = -2047;
      endcase
    end else if (bias > 0) begin
      v = $urandom_range(1024, 2047);
    end else if (bias < 0) begin
      v = -int'($urandom_range(1024, 2048));
    end else begin
      v = int'($urandom_range(0, 4095)) - 2048;
    end
    return v[IN_BITS-1:0];
  endfunction

  // Mostly gains that keep speeds in range, now and then any gain at all.
  function automatic int random_gain();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, GAIN_MAX);
    return $urandom_range(0, 2**18);
  endfunction

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  function automatic void report_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want)
      report_error($sformatf("record %0d %s: expected 0x%08h, got 0x%08h",
                             result_count, name, want, seen));
  endfunction

  // The receiver keeps its own pattern and serves each long hold asked for
  // by a test, counting the held cycles itself.
  initial begin : result_sink
    sink_mode_t mode;
    int         mode_left;
    int         hold_left;
    int         holds_served;
    int         beat;
    mode         = SINK_ALWAYS;
    mode_left    = 0;
    hold_left    = 0;
    holds_served = 0;
    beat         = 0;
    out_tready   = 1'b0;
    forever begin
      @(negedge clk);
      beat++;
      if (holds_served != stall_requests) begin
        holds_served = stall_requests;
        hold_left    = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 120);
        end
        mode_left--;
        case (mode)
          SINK_ALWAYS: out_tready <= 1'b1;
          SINK_COIN:   out_tready <= 1'($urandom_range(0, 1));
          SINK_MOSTLY: out_tready <= ($urandom_range(0, 7) != 0);
          default:     out_tready <= (beat % 6 == 0);
        endcase
      end
    end
  end

  // Every record taken from the block is held against the oldest prediction.
  always @(posedge clk) begin : result_check
    odometry_t want;
    odometry_t seen;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata;
      result_count++;
      if (pending_odometry.size() == 0) begin
        report_error($sformatf("record %0d arrived with no request outstanding",
                               result_count));
      end else begin
        want = pending_odometry.pop_front();
        check_field("right_window_sum", want.right_window_sum, seen.right_window_sum);
        check_field("left_window_sum", want.left_window_sum, seen.left_window_sum);
        check_field("right_speed", want.right_speed, seen.right_speed);
        check_field("left_speed", want.left_speed, seen.left_speed);
        check_field("car_speed", want.car_speed, seen.car_speed);
        check_field("car_speed_cm", want.car_speed_cm, seen.car_speed_cm);
        check_field("right_count_total", want.right_count_total, seen.right_count_total);
        check_field("left_count_total", want.left_count_total, seen.left_count_total);
        check_field("car_distance", want.car_distance, seen.car_distance);
        check_field("left_distance", want.left_distance, seen.left_distance);
        check_field("right_distance", want.right_distance, seen.right_distance);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values read back; an all-ones write to each register must be cut to
  // the register's width; a write past the last register changes nothing.
  task automatic test_register_port();
    for (int i = 0; i <= int'(REG_CM_SCALE); i++) check_register(reg_idx_t'(i));
    for (int i = 0; i <= int'(REG_CM_SCALE); i++) apb_write(reg_addr(reg_idx_t'(i)), '1);
    apb_write(UNUSED_REG_ADDR, 32'h1234_5678);
    for (int i = 0; i <= int'(REG_CM_SCALE); i++) check_register(reg_idx_t'(i));
  endtask

  // The first tick after reset primes both rings. It is sent with the right
  // count negated and at its most negative, so the primed sample saturates.
  // Then the corner counts with each wheel negated in turn.
  task automatic test_priming_ticks();
    apply_settings(1, 0, 24'h00_8000, 24'h01_0000, 5, 16'h0100, 100);
    offer_tick(-12'sd2048, 12'sd2047);
    offer_tick(12'sd2047, -12'sd2048);
    offer_tick(-12'sd2048, -12'sd2048);
    offer_tick(12'sd0, 12'sd0);
    offer_tick(-12'sd1, 12'sd1);
    offer_tick(12'sd1, -12'sd1);
    offer_tick(12'sd2047, 12'sd2047);
    offer_tick(-12'sd2048, 12'sd0);
    wait_idle();
    apply_settings(0, 1, 24'h00_4000, 24'h02_0000, 7, 16'h0280, 250);
    offer_tick(-12'sd2048, -12'sd2048);
    offer_tick(12'sd2047, -12'sd2048);
    offer_tick(12'sd0, 12'sd1);
    offer_tick(12'sd1, 12'sd0);
    wait_idle();
  endtask

  // Largest gain, period, scale and pulses per cm: the speeds saturate at
  // once and the distance accumulators climb fast.
  task automatic test_speed_saturation();
    apply_settings(0, 0, GAIN_MAX, GAIN_MAX, PERIOD_MAX, PPC_MAX, CSCALE_MAX);
    repeat (10) offer_tick(12'sd2047, 12'sd2047);
    wait_idle();
  endtask

  // Zero gain, period, scale and pulses per cm are legal and give zero speeds and distances.
  task automatic test_zero_scaling();
    apply_settings(1, 1, 0, 0, 0, 0, 0);
    offer_tick(-12'sd2048, 12'sd2047);
    offer_tick(12'sd1234, -12'sd777);
    offer_tick(12'sd2047, -12'sd2048);
    wait_idle();
  endtask

  // Phases cycle through random settings, the largest settings with counts
  // pushing forwards and then backwards so that the accumulators reach both
  // limits, and the shortest period with each other setting zero half the time.
  task automatic test_random_phases();
    int bias;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase % 4)
        0: begin
          bias = 0;
          apply_settings($urandom_range(0, 1), $urandom_range(0, 1), random_gain(),
                         random_gain(), $urandom_range(1, PERIOD_MAX),
                         $urandom_range(0, PPC_MAX), $urandom_range(0, CSCALE_MAX));
        end
        1: begin
          bias = 1;
          apply_settings(0, 0, GAIN_MAX, GAIN_MAX, PERIOD_MAX, PPC_MAX, CSCALE_MAX);
        end
        2: begin
          bias = -1;
          apply_settings(0, 0, GAIN_MAX, GAIN_MAX, PERIOD_MAX, PPC_MAX, CSCALE_MAX);
        end
        default: begin
          bias = 0;
          apply_settings($urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 1) ? 0 : random_gain(),
                         $urandom_range(0, 1) ? 0 : random_gain(), 1,
                         $urandom_range(0, 1) ? 0 : PPC_MAX,
                         $urandom_range(0, 1) ? 0 : CSCALE_MAX);
        end
      endcase
      repeat (TICKS_PER_PHASE) begin
        offer_tick(pick_pulses(bias), pick_pulses(bias));
        pace_sender();
      end
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming
  // back to back, so the block fills up and must stall its input.
  task automatic test_backpressure();
    wait_idle();
    stall_requests++;
    repeat (PRESSURE_TICKS) offer_tick(pick_pulses(0), pick_pulses(0));
  endtask

  // --------------------------------------------------------------------------
  // Run
  // --------------------------------------------------------------------------

  initial begin : run_sequence
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    reset_odometry();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_port();
    test_priming_ticks();
    test_speed_saturation();
    test_zero_scaling();
    test_random_phases();
    test_backpressure();

    // Drain, then keep watching for anything unexpected.
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_odometry.size() != 0)
      report_error($sformatf("%0d predicted records never arrived",
                             pending_odometry.size()));
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // A correct run needs well under a tenth of this.
  initial begin : watchdog
    #16_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
